// File: hw/rtl/lcc_pkg.sv
// Package for the lamp color cache: beat structs, command, register and state codes,
// register reset values and the gamma table.
// No dependencies.
`default_nettype none
package lcc_pkg;

	typedef enum logic [1:0] {
		CMD_SET   = 2'd0,
		CMD_RANGE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_FLUSH = 2'd3
	} lcc_cmd_t;

	typedef enum logic [1:0] {
		REG_LAMP_COUNT = 2'd0,
		REG_RATIO_RED  = 2'd1,
		REG_RATIO_GRN  = 2'd2,
		REG_RATIO_BLU  = 2'd3
	} lcc_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_GAMMA,
		ST_RD,
		ST_CMP,
		ST_RESP
	} lcc_state_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] lamp_index;
		logic [7:0] range_end;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       complete;
	} lcc_in_t;

	typedef struct packed {
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic [7:0] out_blue;
		logic [7:0] out_white;
		logic       changed;
		logic       refresh;
		logic [6:0] dirty_count;
		logic       status;
	} lcc_out_t;

	// index and count compares: 8-bit index against a count of up to 256
	localparam int CMP_W = 9;

	localparam logic [6:0]  LAMP_COUNT_RST = 7'd37;
	localparam logic [16:0] RATIO_RED_RST  = 17'd65536;
	localparam logic [16:0] RATIO_GRN_RST  = 17'd52943;
	localparam logic [16:0] RATIO_BLU_RST  = 17'd45233;
	localparam logic [16:0] Q16_ONE        = 17'd65536;

	localparam logic [7:0] GAMMA_ROM [256] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,
		8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
		8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
		8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
		8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
		8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
		8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
		8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
		8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
		8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,
		8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,  8'd25,
		8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,
		8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,
		8'd37,  8'd38,  8'd39,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
		8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd50,
		8'd51,  8'd52,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
		8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,
		8'd69,  8'd70,  8'd72,  8'd73,  8'd74,  8'd75,  8'd77,  8'd78,
		8'd79,  8'd81,  8'd82,  8'd83,  8'd85,  8'd86,  8'd87,  8'd89,
		8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,  8'd99,  8'd101,
		8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
		8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
		8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
		8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
		8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
		8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
		8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
		8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
		8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
	};

endpackage
`default_nettype wire

// File: hw/rtl/lamp_color_cache_rgbw_gamma.sv
// Lamp color cache top level: APB register file, command sequencer, shared white-point
// multiplier, gamma lookup and the lamp color store.
// Depends on lcc_pkg and lcc_ram.
`default_nettype none
// One command beat is taken at a time; cmd_stall stays high until its response beat
// has been loaded into the output register, which may still wait on rsp_stall while
// the next command is taken. The white-point step runs the three color channels
// through one 8x17 multiplier, one channel a cycle; each lamp write is a
// read-compare-write of the color store (registered read), one lamp at a time.
// Stored lamps are tracked by MAX_LAMPS valid flops cleared at reset, so the store
// is ready right after reset with no clear pass.
// Registers: 0x0 lamp_count, 0x4/0x8/0xC white ratios red/green/blue (Q16, values
// above 1.0 act as 1.0).
module lamp_color_cache_rgbw_gamma #(
	parameter int MAX_LAMPS = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [3:0]     paddr,
	input  wire logic [31:0]    pwdata,
	output logic      [31:0]    prdata,
	output logic                pready,
	input  wire logic           cmd_valid,
	output logic                cmd_stall,
	input  wire lcc_pkg::lcc_in_t  cmd_data,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output lcc_pkg::lcc_out_t   rsp_data
);

	localparam int IDX_W = (MAX_LAMPS > 1) ? $clog2(MAX_LAMPS) : 1;

	// registers
	logic [6:0]  lamp_count_q;
	logic [16:0] ratio_red_q;
	logic [16:0] ratio_grn_q;
	logic [16:0] ratio_blu_q;

	// control
	lcc_pkg::lcc_state_t state_q, state_d;
	logic [1:0]           ch_q;
	logic [6:0]           extent_q;
	logic [MAX_LAMPS-1:0] valid_q;
	logic                 rsp_valid_q;

	// payload
	lcc_pkg::lcc_in_t  item_q;
	lcc_pkg::lcc_out_t rsp_q;
	logic              ok_q;
	logic              chg_q;
	logic [7:0]        white_q;
	logic [7:0]        chan_q [3];
	logic [7:0]        cur_q;
	logic [7:0]        end_q;
	logic [31:0]       word_q;

	logic                 ram_we;
	logic                 ram_re;
	logic [31:0]          ram_rdata;
	logic [IDX_W-1:0]     addr;
	logic                 accept;
	logic                 rsp_load;
	logic                 cfg_wr;
	logic                 item_ok;
	logic [lcc_pkg::CMP_W-1:0] n_eff;
	logic                 idx_ok;
	logic                 end_ok;
	logic [7:0]           min_rg;
	logic [7:0]           white_in;
	logic [7:0]           chan_sel;
	logic [16:0]          ratio_sel;
	logic [16:0]          ratio_sat;
	logic [24:0]          prod;
	logic [31:0]          stored;
	logic                 diff;
	logic [7:0]           cur_inc;
	lcc_pkg::lcc_out_t    rsp_d;

	// ---------------- configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		unique case (lcc_pkg::lcc_reg_t'(paddr[3:2]))
			lcc_pkg::REG_LAMP_COUNT: prdata = {25'd0, lamp_count_q};
			lcc_pkg::REG_RATIO_RED:  prdata = {15'd0, ratio_red_q};
			lcc_pkg::REG_RATIO_GRN:  prdata = {15'd0, ratio_grn_q};
			lcc_pkg::REG_RATIO_BLU:  prdata = {15'd0, ratio_blu_q};
			default:                 prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_count_q <= lcc_pkg::LAMP_COUNT_RST;
			ratio_red_q  <= lcc_pkg::RATIO_RED_RST;
			ratio_grn_q  <= lcc_pkg::RATIO_GRN_RST;
			ratio_blu_q  <= lcc_pkg::RATIO_BLU_RST;
		end else if (cfg_wr) begin
			unique case (lcc_pkg::lcc_reg_t'(paddr[3:2]))
				lcc_pkg::REG_LAMP_COUNT: lamp_count_q <= pwdata[6:0];
				lcc_pkg::REG_RATIO_RED:  ratio_red_q  <= pwdata[16:0];
				lcc_pkg::REG_RATIO_GRN:  ratio_grn_q  <= pwdata[16:0];
				lcc_pkg::REG_RATIO_BLU:  ratio_blu_q  <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	// ---------------- command check
	assign n_eff  = ({2'd0, lamp_count_q} < lcc_pkg::CMP_W'(MAX_LAMPS)) ?
	                {2'd0, lamp_count_q} : lcc_pkg::CMP_W'(MAX_LAMPS);
	assign idx_ok = {1'b0, cmd_data.lamp_index} < n_eff;
	assign end_ok = {1'b0, cmd_data.range_end} < n_eff;

	always_comb begin
		unique case (lcc_pkg::lcc_cmd_t'(cmd_data.cmd))
			lcc_pkg::CMD_SET:   item_ok = idx_ok;
			lcc_pkg::CMD_RANGE: item_ok = idx_ok && end_ok &&
			                              (cmd_data.lamp_index <= cmd_data.range_end);
			lcc_pkg::CMD_READ:  item_ok = idx_ok;
			default:            item_ok = 1'b1;
		endcase
	end

	assign min_rg   = (cmd_data.red < cmd_data.green) ? cmd_data.red : cmd_data.green;
	assign white_in = (cmd_data.blue < min_rg) ? cmd_data.blue : min_rg;

	// ---------------- shared white-point multiplier
	always_comb begin
		case (ch_q)
			2'd0:    begin chan_sel = item_q.red;   ratio_sel = ratio_red_q; end
			2'd1:    begin chan_sel = item_q.green; ratio_sel = ratio_grn_q; end
			default: begin chan_sel = item_q.blue;  ratio_sel = ratio_blu_q; end
		endcase
	end

	assign ratio_sat = ratio_sel[16] ? lcc_pkg::Q16_ONE : ratio_sel;
	assign prod      = {17'd0, white_q} * {8'd0, ratio_sat};

	// ---------------- lamp store
	assign addr    = cur_q[IDX_W-1:0];
	assign stored  = valid_q[addr] ? ram_rdata : 32'd0;
	assign diff    = stored != word_q;
	assign cur_inc = cur_q + 8'd1;

	lcc_ram #(
		.WIDTH (32),
		.DEPTH (MAX_LAMPS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (word_q),
		.re    (ram_re),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	// ---------------- sequencer
	assign cmd_stall = state_q != lcc_pkg::ST_IDLE;
	assign accept    = cmd_valid & ~cmd_stall;

	always_comb begin
		state_d  = state_q;
		ram_re   = 1'b0;
		ram_we   = 1'b0;
		rsp_load = 1'b0;
		unique case (state_q)
			lcc_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					if (item_ok && (cmd_data.cmd == lcc_pkg::CMD_SET ||
					                cmd_data.cmd == lcc_pkg::CMD_RANGE)) begin
						state_d = lcc_pkg::ST_MUL;
					end else if (item_ok && cmd_data.cmd == lcc_pkg::CMD_READ) begin
						state_d = lcc_pkg::ST_RD;
					end else begin
						state_d = lcc_pkg::ST_RESP;
					end
				end
			end
			lcc_pkg::ST_MUL: begin
				if (ch_q == 2'd2) begin
					state_d = lcc_pkg::ST_GAMMA;
				end
			end
			lcc_pkg::ST_GAMMA: begin
				state_d = lcc_pkg::ST_RD;
			end
			lcc_pkg::ST_RD: begin
				ram_re  = 1'b1;
				state_d = lcc_pkg::ST_CMP;
			end
			lcc_pkg::ST_CMP: begin
				if (item_q.cmd == lcc_pkg::CMD_READ) begin
					state_d = lcc_pkg::ST_RESP;
				end else begin
					ram_we = 1'b1;
					if (cur_q == end_q) begin
						state_d = lcc_pkg::ST_RESP;
					end else begin
						state_d = lcc_pkg::ST_RD;
					end
				end
			end
			lcc_pkg::ST_RESP: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = lcc_pkg::ST_IDLE;
				end
			end
			default: state_d = lcc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcc_pkg::ST_IDLE;
			ch_q        <= 2'd0;
			extent_q    <= 7'd0;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				ch_q <= 2'd0;
			end else if (state_q == lcc_pkg::ST_MUL) begin
				ch_q <= ch_q + 2'd1;
			end
			if (ram_we) begin
				valid_q[addr] <= 1'b1;
				if (diff && ({1'b0, extent_q} < cur_inc)) begin
					extent_q <= cur_inc[6:0];
				end
			end
			if (rsp_load && item_q.cmd == lcc_pkg::CMD_FLUSH) begin
				extent_q <= 7'd0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q  <= cmd_data;
			ok_q    <= item_ok;
			chg_q   <= 1'b0;
			white_q <= white_in;
			cur_q   <= cmd_data.lamp_index;
			end_q   <= (cmd_data.cmd == lcc_pkg::CMD_RANGE) ? cmd_data.range_end :
			           cmd_data.lamp_index;
		end
		if (state_q == lcc_pkg::ST_MUL) begin
			chan_q[ch_q] <= chan_sel - prod[23:16];
		end
		if (state_q == lcc_pkg::ST_GAMMA) begin
			word_q <= {lcc_pkg::GAMMA_ROM[white_q], lcc_pkg::GAMMA_ROM[chan_q[2]],
			           lcc_pkg::GAMMA_ROM[chan_q[0]], lcc_pkg::GAMMA_ROM[chan_q[1]]};
		end
		if (state_q == lcc_pkg::ST_CMP) begin
			if (item_q.cmd == lcc_pkg::CMD_READ) begin
				word_q <= stored;
			end else begin
				if (diff) begin
					chg_q <= 1'b1;
				end
				cur_q <= cur_inc;
			end
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	// ---------------- response beat
	always_comb begin
		rsp_d = '0;
		rsp_d.dirty_count = extent_q;
		if (item_q.cmd != lcc_pkg::CMD_FLUSH) begin
			rsp_d.status = ~ok_q;
			if (ok_q) begin
				rsp_d.out_green = word_q[7:0];
				rsp_d.out_red   = word_q[15:8];
				rsp_d.out_blue  = word_q[23:16];
				rsp_d.out_white = word_q[31:24];
				if (item_q.cmd != lcc_pkg::CMD_READ) begin
					rsp_d.changed = chg_q;
					rsp_d.refresh = item_q.complete;
				end
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

`ifndef ASSERT_OFF
	a_rsp_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == lcc_pkg::ST_RESP)
		else $error("response beat raised outside the response state");

	a_write_only_on_set: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == lcc_pkg::ST_CMP && item_q.cmd != lcc_pkg::CMD_READ &&
		            ok_q))
		else $error("store write outside a valid set or range");

	a_read_then_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lcc_pkg::ST_RD |=> state_q == lcc_pkg::ST_CMP)
		else $error("read data not consumed the cycle after the read");

	a_mul_channels: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lcc_pkg::ST_MUL |-> ch_q != 2'd3)
		else $error("multiplier channel counter overran");

	a_extent_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, extent_q} <= 8'd127 && {2'd0, extent_q} <= lcc_pkg::CMP_W'(MAX_LAMPS))
		else $error("dirty extent beyond the store");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/lcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lcc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire
